@@ sv/lav_pkg.sv @@
// ============================================================================
// lav_pkg
// Shared types, constants, step, rounding and clamping functions of the look-at view matrix.
// ============================================================================
package lav_pkg;

    localparam int UNIT_W = 32;
    localparam int MAG_W  = 64;
    localparam logic signed [35:0] ONE_Q30_36 = 36'sd1073741824;
    localparam logic signed [35:0] NEG_ONE_Q30_36 = -36'sd1073741824;

    typedef struct packed {
        logic [MAG_W-1:0] n;
        logic [MAG_W-1:0] r;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] low;
        logic [30:0] q;
    } div_t;

    // one iteration of the bitwise integer square root
    function automatic sqrt_t sqrt_step(sqrt_t a, int k);
        sqrt_t            o;
        logic [MAG_W-1:0] b;
        logic [MAG_W-1:0] t;
        b = 64'd1 << (62 - 2 * k);
        t = a.r + b;
        if (a.n >= t)
        begin
            o.n = a.n - t;
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.n = a.n;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit of the restoring division
    function automatic div_t div_step(div_t a, logic [31:0] s);
        div_t        o;
        logic [32:0] t;
        logic        qb;
        t = {a.rem, a.low[30]};
        if (t >= {1'b0, s})
        begin
            o.rem = 32'(t - {1'b0, s});
            qb    = 1'b1;
        end
        else
        begin
            o.rem = t[31:0];
            qb    = 1'b0;
        end
        o.low = {a.low[29:0], 1'b0};
        o.q   = {a.q[29:0], qb};
        return o;
    endfunction

    // round Q.60 or Q.46 to 30 fewer fraction bits, half away from zero
    function automatic logic signed [35:0] rnd30(logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? (~x + 64'd1) : x;
        q   = (mag + (64'd1 << 29)) >> 30;
        return x[63] ? -$signed(q[35:0]) : $signed(q[35:0]);
    endfunction

    function automatic logic signed [31:0] clamp_unit(logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30_36)
            r = ONE_Q30_36[31:0];
        else if (v < NEG_ONE_Q30_36)
            r = NEG_ONE_Q30_36[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ sv/lav_norm.sv @@
// ============================================================================
// lav_norm
// Pipelined 3-vector normalizer: block scaling, sum of squares, bitwise square
// root and restoring division, output in Q2.30 with a sideband carried along.
// ============================================================================
module lav_norm
    import lav_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 192
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [2:0][IN_W-1:0]   in_v,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_vld,
    output logic [2:0][UNIT_W-1:0] out_v,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int LEN_W  = $clog2(IN_W + 1);
    localparam int SQ_IT  = 32;
    localparam int SQ_PER = 2;
    localparam int SQ_ST  = SQ_IT / SQ_PER;
    localparam int DV_IT  = 31;
    localparam int DV_PER = 2;
    localparam int DV_ST  = (DV_IT + DV_PER - 1) / DV_PER;
    localparam int TL     = SQ_ST + DV_ST;

    logic                  a_vld_reg;
    logic [2:0][IN_W-1:0]  a_mag_reg;
    logic [2:0]            a_neg_reg;
    logic [SIDE_W-1:0]     a_side_reg;

    logic                  b_vld_reg;
    logic [LEN_W-1:0]      b_len_reg;
    logic                  b_zero_reg;
    logic [2:0][IN_W-1:0]  b_mag_reg;
    logic [2:0]            b_neg_reg;
    logic [SIDE_W-1:0]     b_side_reg;

    logic                  c_vld_reg;
    logic [2:0][30:0]      c_mn_reg;
    logic                  c_zero_reg;
    logic [2:0]            c_neg_reg;
    logic [SIDE_W-1:0]     c_side_reg;

    logic                  d_vld_reg;
    logic [2:0][61:0]      d_sq_reg;
    logic [2:0][30:0]      d_mn_reg;
    logic                  d_zero_reg;
    logic [2:0]            d_neg_reg;
    logic [SIDE_W-1:0]     d_side_reg;

    logic                  e_vld_reg;
    logic [63:0]           e_sum_reg;
    logic [2:0][30:0]      e_mn_reg;
    logic                  e_zero_reg;
    logic [2:0]            e_neg_reg;
    logic [SIDE_W-1:0]     e_side_reg;

    sqrt_t                 sq_reg   [SQ_ST];
    logic [2:0][30:0]      sq_mn_reg [SQ_ST];
    sqrt_t                 sq_src   [SQ_ST];
    sqrt_t                 sq_next  [SQ_ST];

    div_t [2:0]            dv_reg   [DV_ST];
    logic [31:0]           dv_s_reg [DV_ST];
    div_t [2:0]            dv_src   [DV_ST];
    logic [31:0]           dv_s_src [DV_ST];
    div_t [2:0]            dv_next  [DV_ST];

    logic                  t_vld_reg  [TL];
    logic [2:0]            t_neg_reg  [TL];
    logic                  t_zero_reg [TL];
    logic [SIDE_W-1:0]     t_side_reg [TL];

    logic                  o_vld_reg;
    logic [2:0][UNIT_W-1:0] o_v_reg;
    logic [SIDE_W-1:0]     o_side_reg;

    logic [2:0][IN_W-1:0]  a_mag_next;
    logic [2:0]            a_neg_next;
    logic [IN_W-1:0]       b_or;
    logic [LEN_W-1:0]      b_len_next;
    logic [2:0][30:0]      c_mn_next;
    logic [IN_W-1:0]       c_shift;
    logic [61:0]           dv_num;
    logic [2:0][UNIT_W-1:0] o_v_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = in_v[i][IN_W-1];
            a_mag_next[i] = a_neg_next[i] ? (~in_v[i] + 1'b1) : in_v[i];
        end
    end

    always_comb
    begin
        b_or       = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        b_len_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (b_or[i])
                b_len_next = LEN_W'(i + 1);
        end
    end

    always_comb
    begin
        c_shift = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (b_len_reg > LEN_W'(31))
                c_shift = b_mag_reg[i] >> (b_len_reg - LEN_W'(31));
            else
                c_shift = b_mag_reg[i] << (LEN_W'(31) - b_len_reg);
            c_mn_next[i] = c_shift[30:0];
        end
    end

    always_comb
    begin
        for (int j = 0; j < SQ_ST; j++)
        begin
            if (j == 0)
                sq_src[j] = '{n: e_sum_reg, r: '0};
            else
                sq_src[j] = sq_reg[j-1];
            sq_next[j] = sqrt_step(sqrt_step(sq_src[j], SQ_PER * j), SQ_PER * j + 1);
        end
    end

    always_comb
    begin
        dv_num = '0;
        for (int j = 0; j < DV_ST; j++)
        begin
            if (j == 0)
            begin
                dv_s_src[j] = sq_reg[SQ_ST-1].r[31:0];
                for (int i = 0; i < 3; i++)
                begin
                    dv_num = (62'(sq_mn_reg[SQ_ST-1][i]) << 30) + 62'(dv_s_src[j] >> 1);
                    dv_src[j][i] = '{rem: 32'(dv_num[61:31]), low: dv_num[30:0], q: '0};
                end
            end
            else
            begin
                dv_s_src[j] = dv_s_reg[j-1];
                dv_src[j]   = dv_reg[j-1];
            end
            dv_next[j] = dv_src[j];
            for (int p = 0; p < DV_PER; p++)
            begin
                if (j * DV_PER + p < DV_IT)
                begin
                    for (int i = 0; i < 3; i++)
                        dv_next[j][i] = div_step(dv_next[j][i], dv_s_src[j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (t_zero_reg[TL-1])
                o_v_next[i] = '0;
            else if (t_neg_reg[TL-1][i])
                o_v_next[i] = UNIT_W'(0) - {1'b0, dv_reg[DV_ST-1][i].q};
            else
                o_v_next[i] = {1'b0, dv_reg[DV_ST-1][i].q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            for (int k = 0; k < TL; k++)
                t_vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            t_vld_reg[0] <= e_vld_reg;
            for (int k = 1; k < TL; k++)
                t_vld_reg[k] <= t_vld_reg[k-1];
            o_vld_reg <= t_vld_reg[TL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_side_reg <= in_side;

            b_len_reg  <= b_len_next;
            b_zero_reg <= (b_or == '0);
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;

            c_mn_reg   <= c_mn_next;
            c_zero_reg <= b_zero_reg;
            c_neg_reg  <= b_neg_reg;
            c_side_reg <= b_side_reg;

            for (int i = 0; i < 3; i++)
                d_sq_reg[i] <= 62'(c_mn_reg[i]) * 62'(c_mn_reg[i]);
            d_mn_reg   <= c_mn_reg;
            d_zero_reg <= c_zero_reg;
            d_neg_reg  <= c_neg_reg;
            d_side_reg <= c_side_reg;

            e_sum_reg  <= 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);
            e_mn_reg   <= d_mn_reg;
            e_zero_reg <= d_zero_reg;
            e_neg_reg  <= d_neg_reg;
            e_side_reg <= d_side_reg;

            for (int j = 0; j < SQ_ST; j++)
            begin
                sq_reg[j]    <= sq_next[j];
                sq_mn_reg[j] <= (j == 0) ? e_mn_reg : sq_mn_reg[j-1];
            end
            for (int j = 0; j < DV_ST; j++)
            begin
                dv_reg[j]   <= dv_next[j];
                dv_s_reg[j] <= dv_s_src[j];
            end

            t_neg_reg[0]  <= e_neg_reg;
            t_zero_reg[0] <= e_zero_reg;
            t_side_reg[0] <= e_side_reg;
            for (int k = 1; k < TL; k++)
            begin
                t_neg_reg[k]  <= t_neg_reg[k-1];
                t_zero_reg[k] <= t_zero_reg[k-1];
                t_side_reg[k] <= t_side_reg[k-1];
            end

            o_v_reg    <= o_v_next;
            o_side_reg <= t_side_reg[TL-1];
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_v    = o_v_reg;
    assign out_side = o_side_reg;

endmodule

@@ sv/look_at_view_matrix.sv @@
// ============================================================================
// look_at_view_matrix
// Fixed-point look-at view matrix: rotation rows in Q2.30, translation Q20.16.
// ============================================================================
// Fully pipelined: one item enters per clock while the output is not stalled. The
// result passes through the two normalizers (each: block scaling, a 16-stage
// square root at two bits per stage and a 16-stage divider at up to two quotient
// bits per stage) and nine more stages of differences, cross and dot products. When
// m_tready is low with a result waiting, the whole pipeline holds.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, updir_x, updir_y, updir_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // side_x/y/z, trueup_x/y/z, back_x/y/z (32 each), shift_x/y/z (36 each), 4 pad
    output logic [399:0] m_tdata
);

    localparam int N1_SIDE = 192;
    localparam int N2_SIDE = 256;

    logic adv;

    logic signed [31:0] in_eye [3];
    logic signed [31:0] in_tgt [3];
    logic signed [31:0] in_up  [3];

    logic               t1_vld_reg;
    logic signed [32:0] t1_d_reg   [3];
    logic signed [31:0] t1_eye_reg [3];
    logic signed [31:0] t1_up_reg  [3];

    logic [2:0][32:0]     n1_in;
    logic [N1_SIDE-1:0]   n1_side_in;
    logic                 n1_vld;
    logic [2:0][UNIT_W-1:0] n1_v;
    logic [N1_SIDE-1:0]   n1_side;
    logic signed [31:0]   n1_fw  [3];
    logic signed [31:0]   n1_eye [3];
    logic signed [31:0]   n1_up  [3];

    logic               c1_vld_reg;
    logic signed [31:0] c1_fw_reg  [3];
    logic signed [31:0] c1_eye_reg [3];
    logic signed [62:0] c1_pc_reg  [6];
    logic signed [62:0] c1_pe_reg  [3];

    logic               c2_vld_reg;
    logic signed [63:0] c2_c_reg   [3];
    logic signed [63:0] c2_dz_reg;
    logic signed [31:0] c2_fw_reg  [3];
    logic signed [31:0] c2_eye_reg [3];

    logic [2:0][63:0]     n2_in;
    logic [N2_SIDE-1:0]   n2_side_in;
    logic                 n2_vld;
    logic [2:0][UNIT_W-1:0] n2_v;
    logic [N2_SIDE-1:0]   n2_side;
    logic signed [31:0]   n2_sd  [3];
    logic signed [31:0]   n2_fw  [3];
    logic signed [31:0]   n2_eye [3];
    logic signed [63:0]   n2_dz;

    logic               p1_vld_reg;
    logic signed [31:0] p1_sd_reg  [3];
    logic signed [31:0] p1_fw_reg  [3];
    logic signed [31:0] p1_eye_reg [3];
    logic signed [63:0] p1_dz_reg;
    logic signed [61:0] p1_pt_reg  [6];
    logic signed [62:0] p1_px_reg  [3];

    logic               p2_vld_reg;
    logic signed [31:0] p2_sd_reg  [3];
    logic signed [31:0] p2_fw_reg  [3];
    logic signed [31:0] p2_eye_reg [3];
    logic signed [63:0] p2_dz_reg;
    logic signed [63:0] p2_tuw_reg [3];
    logic signed [63:0] p2_dx_reg;

    logic               p3_vld_reg;
    logic signed [31:0] p3_sd_reg  [3];
    logic signed [31:0] p3_fw_reg  [3];
    logic signed [31:0] p3_eye_reg [3];
    logic signed [31:0] p3_tu_reg  [3];
    logic signed [35:0] p3_shx_reg;
    logic signed [35:0] p3_shz_reg;

    logic               p4_vld_reg;
    logic signed [31:0] p4_sd_reg  [3];
    logic signed [31:0] p4_fw_reg  [3];
    logic signed [31:0] p4_tu_reg  [3];
    logic signed [63:0] p4_py_reg  [3];
    logic signed [35:0] p4_shx_reg;
    logic signed [35:0] p4_shz_reg;

    logic               p5_vld_reg;
    logic signed [31:0] p5_sd_reg  [3];
    logic signed [31:0] p5_fw_reg  [3];
    logic signed [31:0] p5_tu_reg  [3];
    logic signed [63:0] p5_dy_reg;
    logic signed [35:0] p5_shx_reg;
    logic signed [35:0] p5_shz_reg;

    logic               o_vld_reg;
    logic signed [31:0] o_side_reg [3];
    logic signed [31:0] o_tu_reg   [3];
    logic signed [31:0] o_back_reg [3];
    logic signed [35:0] o_sh_reg   [3];

    assign adv      = !o_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {4'd0, o_sh_reg[2], o_sh_reg[1], o_sh_reg[0],
                       o_back_reg[2], o_back_reg[1], o_back_reg[0],
                       o_tu_reg[2], o_tu_reg[1], o_tu_reg[0],
                       o_side_reg[2], o_side_reg[1], o_side_reg[0]};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_eye[i] = s_tdata[32*i +: 32];
            in_tgt[i] = s_tdata[96 + 32*i +: 32];
            in_up[i]  = s_tdata[192 + 32*i +: 32];
            n1_in[i]  = t1_d_reg[i];
            n2_in[i]  = c2_c_reg[i];
        end
        n1_side_in = {t1_up_reg[2], t1_up_reg[1], t1_up_reg[0],
                      t1_eye_reg[2], t1_eye_reg[1], t1_eye_reg[0]};
        n2_side_in = {c2_dz_reg, c2_fw_reg[2], c2_fw_reg[1], c2_fw_reg[0],
                      c2_eye_reg[2], c2_eye_reg[1], c2_eye_reg[0]};
        for (int i = 0; i < 3; i++)
        begin
            n1_fw[i]  = n1_v[i];
            n1_eye[i] = n1_side[32*i +: 32];
            n1_up[i]  = n1_side[96 + 32*i +: 32];
            n2_sd[i]  = n2_v[i];
            n2_eye[i] = n2_side[32*i +: 32];
            n2_fw[i]  = n2_side[96 + 32*i +: 32];
        end
        n2_dz = n2_side[N2_SIDE-1 -: 64];
    end

    lav_norm #(
        .IN_W   (33),
        .SIDE_W (N1_SIDE)
    ) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (t1_vld_reg),
        .in_v     (n1_in),
        .in_side  (n1_side_in),
        .out_vld  (n1_vld),
        .out_v    (n1_v),
        .out_side (n1_side)
    );

    lav_norm #(
        .IN_W   (64),
        .SIDE_W (N2_SIDE)
    ) u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (c2_vld_reg),
        .in_v     (n2_in),
        .in_side  (n2_side_in),
        .out_vld  (n2_vld),
        .out_v    (n2_v),
        .out_side (n2_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            t1_vld_reg <= s_tvalid;
            c1_vld_reg <= n1_vld;
            c2_vld_reg <= c1_vld_reg;
            p1_vld_reg <= n2_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            o_vld_reg  <= p5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t1_d_reg[i]   <= 33'(in_tgt[i]) - 33'(in_eye[i]);
                t1_eye_reg[i] <= in_eye[i];
                t1_up_reg[i]  <= in_up[i];
            end

            c1_fw_reg  <= n1_fw;
            c1_eye_reg <= n1_eye;
            c1_pc_reg[0] <= 63'(n1_fw[1]) * 63'(n1_up[2]);
            c1_pc_reg[1] <= 63'(n1_fw[2]) * 63'(n1_up[1]);
            c1_pc_reg[2] <= 63'(n1_fw[2]) * 63'(n1_up[0]);
            c1_pc_reg[3] <= 63'(n1_fw[0]) * 63'(n1_up[2]);
            c1_pc_reg[4] <= 63'(n1_fw[0]) * 63'(n1_up[1]);
            c1_pc_reg[5] <= 63'(n1_fw[1]) * 63'(n1_up[0]);
            for (int i = 0; i < 3; i++)
                c1_pe_reg[i] <= 63'(n1_fw[i]) * 63'(n1_eye[i]);

            c2_fw_reg  <= c1_fw_reg;
            c2_eye_reg <= c1_eye_reg;
            c2_c_reg[0] <= 64'(c1_pc_reg[0]) - 64'(c1_pc_reg[1]);
            c2_c_reg[1] <= 64'(c1_pc_reg[2]) - 64'(c1_pc_reg[3]);
            c2_c_reg[2] <= 64'(c1_pc_reg[4]) - 64'(c1_pc_reg[5]);
            c2_dz_reg   <= 64'(c1_pe_reg[0]) + 64'(c1_pe_reg[1]) + 64'(c1_pe_reg[2]);

            p1_sd_reg  <= n2_sd;
            p1_fw_reg  <= n2_fw;
            p1_eye_reg <= n2_eye;
            p1_dz_reg  <= n2_dz;
            p1_pt_reg[0] <= 62'(n2_sd[1]) * 62'(n2_fw[2]);
            p1_pt_reg[1] <= 62'(n2_sd[2]) * 62'(n2_fw[1]);
            p1_pt_reg[2] <= 62'(n2_sd[2]) * 62'(n2_fw[0]);
            p1_pt_reg[3] <= 62'(n2_sd[0]) * 62'(n2_fw[2]);
            p1_pt_reg[4] <= 62'(n2_sd[0]) * 62'(n2_fw[1]);
            p1_pt_reg[5] <= 62'(n2_sd[1]) * 62'(n2_fw[0]);
            for (int i = 0; i < 3; i++)
                p1_px_reg[i] <= 63'(n2_sd[i]) * 63'(n2_eye[i]);

            p2_sd_reg  <= p1_sd_reg;
            p2_fw_reg  <= p1_fw_reg;
            p2_eye_reg <= p1_eye_reg;
            p2_dz_reg  <= p1_dz_reg;
            p2_tuw_reg[0] <= 64'(p1_pt_reg[0]) - 64'(p1_pt_reg[1]);
            p2_tuw_reg[1] <= 64'(p1_pt_reg[2]) - 64'(p1_pt_reg[3]);
            p2_tuw_reg[2] <= 64'(p1_pt_reg[4]) - 64'(p1_pt_reg[5]);
            p2_dx_reg <= 64'(p1_px_reg[0]) + 64'(p1_px_reg[1]) + 64'(p1_px_reg[2]);

            p3_sd_reg  <= p2_sd_reg;
            p3_fw_reg  <= p2_fw_reg;
            p3_eye_reg <= p2_eye_reg;
            for (int i = 0; i < 3; i++)
                p3_tu_reg[i] <= clamp_unit(rnd30(p2_tuw_reg[i]));
            p3_shx_reg <= -rnd30(p2_dx_reg);
            p3_shz_reg <= rnd30(p2_dz_reg);

            p4_sd_reg  <= p3_sd_reg;
            p4_fw_reg  <= p3_fw_reg;
            p4_tu_reg  <= p3_tu_reg;
            p4_shx_reg <= p3_shx_reg;
            p4_shz_reg <= p3_shz_reg;
            for (int i = 0; i < 3; i++)
                p4_py_reg[i] <= 64'(p3_tu_reg[i]) * 64'(p3_eye_reg[i]);

            p5_sd_reg  <= p4_sd_reg;
            p5_fw_reg  <= p4_fw_reg;
            p5_tu_reg  <= p4_tu_reg;
            p5_shx_reg <= p4_shx_reg;
            p5_shz_reg <= p4_shz_reg;
            p5_dy_reg  <= p4_py_reg[0] + p4_py_reg[1] + p4_py_reg[2];

            for (int i = 0; i < 3; i++)
            begin
                o_side_reg[i] <= p5_sd_reg[i];
                o_tu_reg[i]   <= p5_tu_reg[i];
                o_back_reg[i] <= -p5_fw_reg[i];
            end
            o_sh_reg[0] <= p5_shx_reg;
            o_sh_reg[1] <= -rnd30(p5_dy_reg);
            o_sh_reg[2] <= p5_shz_reg;
        end
    end

    a_back_unit: assert property (@(posedge clk) disable iff (!rst_n)
        o_vld_reg |-> (o_back_reg[0] <= 32'sd1073741824 && o_back_reg[0] >= -32'sd1073741824
                    && o_back_reg[1] <= 32'sd1073741824 && o_back_reg[1] >= -32'sd1073741824
                    && o_back_reg[2] <= 32'sd1073741824 && o_back_reg[2] >= -32'sd1073741824))
        else $error("back vector out of unit range");

    a_eye_on_target: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_back_reg[0] == 0 && o_back_reg[1] == 0 && o_back_reg[2] == 0)
        |-> (o_side_reg[0] == 0 && o_side_reg[1] == 0 && o_side_reg[2] == 0
             && o_sh_reg[2] == 0))
        else $error("zero forward with nonzero side or shift");

    a_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_side_reg[0] == 0 && o_side_reg[1] == 0 && o_side_reg[2] == 0)
        |-> (o_tu_reg[0] == 0 && o_tu_reg[1] == 0 && o_tu_reg[2] == 0
             && o_sh_reg[0] == 0 && o_sh_reg[1] == 0))
        else $error("zero side with nonzero true up or shift");

endmodule
